// ----- hdl/lzss_stream_decompressor_unit_assert.svh -----
// ---------------------------------------------------------------------------
// lzss stream decompressor assertion macros
// checks sampled on clk, disabled while rst is high
// ---------------------------------------------------------------------------
`ifndef LZSS_STREAM_DECOMPRESSOR_UNIT_ASSERT_SVH
`define LZSS_STREAM_DECOMPRESSOR_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LZSS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lzss same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define LZSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lzss next-cycle check failed");

`endif

// ----- hdl/lzss_pkg.sv -----
// ---------------------------------------------------------------------------
// lzss package
// shared constants and the control bundle of the history ring
// ---------------------------------------------------------------------------
package lzss_pkg;

  localparam int HISTORY_DEPTH_DEF = 4096;
  // match distance reaches 4096, so it needs 13 bits
  localparam int DIST_W = 13;

  typedef struct packed {
    logic       load_src;
    logic       rd_en;
    logic       wr_en;
    logic [7:0] wr_data;
  } ring_ctl_t;

endpackage

// ----- hdl/lzss_ring.sv -----
// ---------------------------------------------------------------------------
// lzss history ring
// single memory with write pointer and copy source pointer, registered read
// ---------------------------------------------------------------------------
module lzss_ring #(
  parameter int HISTORY_DEPTH = lzss_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lzss_pkg::ring_ctl_t       ctl,
  input  logic [lzss_pkg::DIST_W-1:0] match_dist,
  output logic [7:0]                rd_data
);
  import lzss_pkg::*;

  localparam int PW = $clog2(HISTORY_DEPTH);
  localparam logic [PW-1:0] LAST_IDX = PW'(HISTORY_DEPTH - 1);
  localparam logic [PW:0]   DEPTH_EXT = (PW+1)'(HISTORY_DEPTH);

  logic [7:0]    mem [HISTORY_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] src;
  logic [PW-1:0] src_start;
  logic [PW:0]   wp_ext;
  logic [PW:0]   dist_ext;

  assign wp_ext   = {1'b0, wp};
  assign dist_ext = (PW+1)'(match_dist);

  // source behind the write pointer, wrapped into the ring
  always_comb begin
    if (wp_ext >= dist_ext) begin
      src_start = PW'(wp_ext - dist_ext);
    end else begin
      src_start = PW'(wp_ext + DEPTH_EXT - dist_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wp] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[src];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      src <= '0;
    end else begin
      if (ctl.wr_en) begin
        wp <= (wp == LAST_IDX) ? '0 : wp + PW'(1);
      end
      if (ctl.load_src) begin
        src <= src_start;
      end else if (ctl.rd_en) begin
        src <= (src == LAST_IDX) ? '0 : src + PW'(1);
      end
    end
  end

endmodule

// ----- hdl/lzss_stream_decompressor_unit.sv -----
// ---------------------------------------------------------------------------
// lzss stream decompressor unit
// token parser and byte sequencer around a single history ring
// ---------------------------------------------------------------------------
// Takes one compressed byte per request and returns decompressed bytes, one
// per request on the output. A flag byte or the first byte of a match is
// taken without leaving the idle state. A literal is the request, then a
// state with the input held off while the byte is written and presented. A
// match copies its 2 to 16 bytes through the single history memory, each
// byte in two steps (read the source entry, then write it back and present
// it); the end marker is presented from its own state. A result waiting on
// the output register holds the literal, write-back and end steps while the
// consumer stalls. After the end marker all input is taken and dropped until
// reset.
module lzss_stream_decompressor_unit #(
  parameter int HISTORY_DEPTH = lzss_pkg::HISTORY_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       end_of_stream
);
  import lzss_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LIT, S_READ, S_PUT, S_END} state_t;
  typedef enum logic [1:0] {PH_FLAG, PH_TOKEN, PH_MATCH2} phase_t;

  state_t      state;
  phase_t      parse_phase;
  logic [7:0]  flag_bits;
  logic [2:0]  token_count;
  logic [7:0]  offset_high;
  logic        stream_done;
  logic [7:0]  lit_byte;
  logic [3:0]  run_cnt;

  ring_ctl_t         ring_ctl;
  logic [DIST_W-1:0] match_dist;
  logic [7:0]        rd_data;
  logic              in_acc;
  logic              out_free;
  logic              out_load;
  logic              start_copy;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign out_load = out_free && (state == S_LIT || state == S_PUT || state == S_END);

  assign match_dist = DIST_W'({offset_high, in_byte[7:4]}) + DIST_W'(1);
  assign start_copy = in_acc && !stream_done && parse_phase == PH_MATCH2
                      && in_byte[3:0] != 4'd0;

  always_comb begin
    ring_ctl.load_src = start_copy;
    ring_ctl.rd_en    = (state == S_READ);
    ring_ctl.wr_en    = out_free && (state == S_LIT || state == S_PUT);
    ring_ctl.wr_data  = (state == S_LIT) ? lit_byte : rd_data;
  end

  lzss_ring #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_ring (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ring_ctl),
    .match_dist (match_dist),
    .rd_data    (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      parse_phase <= PH_FLAG;
      flag_bits   <= '0;
      token_count <= '0;
      offset_high <= '0;
      stream_done <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc && !stream_done) begin
            case (parse_phase)
              PH_TOKEN: begin
                if (flag_bits[0]) begin
                  offset_high <= in_byte;
                  parse_phase <= PH_MATCH2;
                end else begin
                  lit_byte <= in_byte;
                  state    <= S_LIT;
                end
              end
              PH_MATCH2: begin
                if (in_byte[3:0] == 4'd0) begin
                  stream_done <= 1'b1;
                  parse_phase <= PH_FLAG;
                  state       <= S_END;
                end else begin
                  run_cnt <= in_byte[3:0];
                  state   <= S_READ;
                end
              end
              default: begin
                flag_bits   <= in_byte;
                parse_phase <= PH_TOKEN;
              end
            endcase
          end
        end
        S_LIT: begin
          if (out_free) begin
            out_byte      <= lit_byte;
            last_of_run   <= 1'b1;
            end_of_stream <= 1'b0;
            flag_bits     <= flag_bits >> 1;
            token_count   <= token_count + 3'd1;
            parse_phase   <= (token_count == 3'd7) ? PH_FLAG : PH_TOKEN;
            state         <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_PUT;
        end
        S_PUT: begin
          if (out_free) begin
            out_byte      <= rd_data;
            last_of_run   <= (run_cnt == 4'd0);
            end_of_stream <= 1'b0;
            if (run_cnt == 4'd0) begin
              flag_bits   <= flag_bits >> 1;
              token_count <= token_count + 3'd1;
              parse_phase <= (token_count == 3'd7) ? PH_FLAG : PH_TOKEN;
              state       <= S_IDLE;
            end else begin
              run_cnt <= run_cnt - 4'd1;
              state   <= S_READ;
            end
          end
        end
        S_END: begin
          if (out_free) begin
            out_byte      <= 8'd0;
            last_of_run   <= 1'b1;
            end_of_stream <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "lzss_stream_decompressor_unit_assert.svh"

  // end result carries a zero byte and closes its run
  `LZSS_ASSERT_SAME(a_end_result, out_valid && end_of_stream, last_of_run && out_byte == 8'd0)
  // once the stream has ended, idle input never produces a result
  `LZSS_ASSERT_SAME(a_done_silent, stream_done && state == S_IDLE, !out_load)
  // the final byte of a copy hands control back to the parser
  `LZSS_ASSERT_NEXT(a_copy_ends, state == S_PUT && out_load && run_cnt == 4'd0, in_ready)

endmodule
